[src/bcca_pkg.sv]
`timescale 1ns / 1ps

package bcca_pkg;

  // Field widths
  localparam int unsigned CoordW = 10;
  localparam int unsigned DimW   = 11;
  localparam int unsigned LogW   = 3;
  localparam int unsigned AddrW  = 30;
  localparam int unsigned BxW    = 11;   // bricks along x, up to MAX_DIM
  localparam int unsigned BxByW  = 21;   // bricks in one xy slab, up to MAX_DIM^2
  localparam int unsigned OffW   = 5;    // offset inside a brick on one axis
  localparam int unsigned InnerW = 15;   // offset inside a brick, all axes
  localparam int unsigned NumCorners = 8;

  localparam logic [DimW-1:0] MaxDim     = 11'd1024;
  localparam logic [LogW-1:0] MaxLog     = 3'd5;
  localparam logic [DimW-1:0] DimReset   = 11'd256;
  localparam logic [LogW-1:0] LogReset   = 3'd1;
  localparam logic [BxByW-1:0] BxByReset = 21'd16384;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegDimX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDimY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDimZ     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBrickLog = 3'd3;

  // Settled configuration as seen by the datapath
  typedef struct packed {
    logic [LogW-1:0]  lg;     // brick exponent, clamped to five
    logic [BxW-1:0]   bx;     // bricks along x
    logic [BxByW-1:0] bxby;   // bricks in one xy slab
    logic [DimW-1:0]  lim_x;  // clamped dimensions for the range check
    logic [DimW-1:0]  lim_y;
    logic [DimW-1:0]  lim_z;
  } cfg_t;

  // Per-axis terms for the low and high corner on each axis
  typedef struct packed {
    logic [1:0][BxW-1:0]   xb;
    logic [1:0][BxByW-1:0] yt;
    logic [1:0][AddrW-1:0] zt;
    logic [1:0][OffW-1:0]  ix;
    logic [1:0][OffW-1:0]  iy;
    logic [1:0][OffW-1:0]  iz;
    logic                  oor;
  } term_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    return (d > MaxDim) ? MaxDim : d;
  endfunction

  function automatic logic [LogW-1:0] clamp_log(input logic [LogW-1:0] l);
    return (l > MaxLog) ? MaxLog : l;
  endfunction

endpackage

[src/bcca_cfg.sv]
`timescale 1ns / 1ps

module bcca_cfg import bcca_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [DimW-1:0]    data_i,
  output cfg_t               cfg_o
);

  logic [DimW-1:0]  dim_x_q, dim_y_q, dim_z_q;
  logic [LogW-1:0]  log_q;
  logic [BxByW-1:0] bxby_d, bxby_q;
  logic [DimW-1:0]  cl_x, cl_y;
  logic [LogW-1:0]  lg;
  logic [BxW-1:0]   bx, by;
  logic [2*BxW-1:0] prod;

  // Register writes; unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DimReset;
      dim_y_q <= DimReset;
      dim_z_q <= DimReset;
      log_q   <= LogReset;
    end else if (wr_i) begin
      case (idx_i)
        RegDimX:     dim_x_q <= data_i;
        RegDimY:     dim_y_q <= data_i;
        RegDimZ:     dim_z_q <= data_i;
        RegBrickLog: log_q   <= data_i[LogW-1:0];
        default: ;
      endcase
    end
  end

  // Brick counts
  always_comb begin
    lg     = clamp_log(log_q);
    cl_x   = clamp_dim(dim_x_q);
    cl_y   = clamp_dim(dim_y_q);
    bx     = cl_x >> lg;
    by     = cl_y >> lg;
    prod   = bx * by;
    bxby_d = prod[BxByW-1:0];
  end

  // Slab size kept in a register to keep the multiplier off the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bxby_q <= BxByReset;
    end else begin
      bxby_q <= bxby_d;
    end
  end

  assign cfg_o.lg    = lg;
  assign cfg_o.bx    = bx;
  assign cfg_o.bxby  = bxby_q;
  assign cfg_o.lim_x = cl_x;
  assign cfg_o.lim_y = cl_y;
  assign cfg_o.lim_z = clamp_dim(dim_z_q);

endmodule

[src/bcca_term.sv]
`timescale 1ns / 1ps

module bcca_term import bcca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              vld_i,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [CoordW-1:0] z_i,
  output logic              vld_o,
  output term_t             term_o
);

  term_t              term_d, term_q;
  logic               vld_q;
  logic [1:0][BxW-1:0] ci_x, ci_y, ci_z;
  logic [BxW-1:0]     yb, zb;
  logic [2*BxW-1:0]   yprod;
  logic [BxW+BxByW-1:0] zprod;
  logic [OffW-1:0]    msk;

  // Brick index and slab products for the low and high corner on each axis
  always_comb begin
    term_d = '0;
    yb     = '0;
    zb     = '0;
    yprod  = '0;
    zprod  = '0;
    msk    = OffW'((6'd1 << cfg_i.lg) - 6'd1);
    ci_x[0] = {1'b0, x_i};
    ci_y[0] = {1'b0, y_i};
    ci_z[0] = {1'b0, z_i};
    ci_x[1] = {1'b0, x_i} + 11'd1;
    ci_y[1] = {1'b0, y_i} + 11'd1;
    ci_z[1] = {1'b0, z_i} + 11'd1;
    for (int k = 0; k < 2; k++) begin
      term_d.xb[k] = ci_x[k] >> cfg_i.lg;
      yb           = ci_y[k] >> cfg_i.lg;
      zb           = ci_z[k] >> cfg_i.lg;
      yprod        = yb * cfg_i.bx;
      zprod        = zb * cfg_i.bxby;
      term_d.yt[k] = yprod[BxByW-1:0];
      term_d.zt[k] = zprod[AddrW-1:0];
      term_d.ix[k] = ci_x[k][OffW-1:0] & msk;
      term_d.iy[k] = ci_y[k][OffW-1:0] & msk;
      term_d.iz[k] = ci_z[k][OffW-1:0] & msk;
    end
    // far corner outside the volume: c + 2 > dim
    term_d.oor = ({2'b00, x_i} + 12'd2 > {1'b0, cfg_i.lim_x})
               | ({2'b00, y_i} + 12'd2 > {1'b0, cfg_i.lim_y})
               | ({2'b00, z_i} + 12'd2 > {1'b0, cfg_i.lim_z});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign vld_o  = vld_q;
  assign term_o = term_q;

endmodule

[src/bcca_asm.sv]
`timescale 1ns / 1ps

module bcca_asm import bcca_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [LogW-1:0]                   lg_i,
  input  logic                              vld_i,
  input  term_t                             term_i,
  output logic                              done_o,
  output logic [NumCorners-1:0][AddrW-1:0]  addr_o,
  output logic                              oor_o
);

  logic [NumCorners-1:0][AddrW-1:0]  addr_d, addr_q;
  logic [NumCorners-1:0][AddrW-1:0]  brick;
  logic [NumCorners-1:0][InnerW-1:0] inner;
  logic [3:0] sh2, sh3;
  logic       done_q, oor_q;

  // Per corner: brick number shifted up by the brick volume, offset in the low bits
  always_comb begin
    sh2 = {lg_i, 1'b0};
    sh3 = sh2 + {1'b0, lg_i};
    for (int c = 0; c < NumCorners; c++) begin
      brick[c] = AddrW'(term_i.xb[c[0]]) + AddrW'(term_i.yt[c[1]]) + term_i.zt[c[2]];
      inner[c] = InnerW'(term_i.ix[c[0]])
               | (InnerW'(term_i.iy[c[1]]) << lg_i)
               | (InnerW'(term_i.iz[c[2]]) << sh2);
      addr_d[c] = (brick[c] << sh3) | AddrW'(inner[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    oor_q  <= term_i.oor;
  end

  assign done_o = done_q;
  assign addr_o = addr_q;
  assign oor_o  = oor_q;

endmodule

[src/brick_cell_corner_addresses_unit.sv]
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// request   start / busy              cell_x_i, cell_y_i, cell_z_i
// result    done_o (one-cycle strobe) addr_000_o .. addr_111_o, out_of_range_o
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle; busy stays low and the config port is always ready.
// From the accepting edge to the result, a request passes the input register,
// the per-axis multiply register and the result register.
// Reset clears the valid pipeline and restores the registers to 256/256/256, edge 2.
// Results are strobed once and cannot be held off.

module brick_cell_corner_addresses_unit import bcca_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [CoordW-1:0]  cell_x_i,
  input  logic [CoordW-1:0]  cell_y_i,
  input  logic [CoordW-1:0]  cell_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  output logic               done_o,
  output logic [AddrW-1:0]   addr_000_o,
  output logic [AddrW-1:0]   addr_100_o,
  output logic [AddrW-1:0]   addr_010_o,
  output logic [AddrW-1:0]   addr_110_o,
  output logic [AddrW-1:0]   addr_001_o,
  output logic [AddrW-1:0]   addr_101_o,
  output logic [AddrW-1:0]   addr_011_o,
  output logic [AddrW-1:0]   addr_111_o,
  output logic               out_of_range_o
);

  cfg_t              cfg;
  term_t             term;
  logic              term_vld;
  logic              in_vld_q;
  logic [CoordW-1:0] x_q, y_q, z_q;
  logic [NumCorners-1:0][AddrW-1:0] addr;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  bcca_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i & cfg_ready_o),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      x_q <= cell_x_i;
      y_q <= cell_y_i;
      z_q <= cell_z_i;
    end
  end

  bcca_term u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .vld_i  (in_vld_q),
    .x_i    (x_q),
    .y_i    (y_q),
    .z_i    (z_q),
    .vld_o  (term_vld),
    .term_o (term)
  );

  bcca_asm u_asm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lg_i   (cfg.lg),
    .vld_i  (term_vld),
    .term_i (term),
    .done_o (done_o),
    .addr_o (addr),
    .oor_o  (out_of_range_o)
  );

  // Corner order matches the bit order a + 2b + 4c of addr_abc
  assign addr_000_o = addr[0];
  assign addr_100_o = addr[1];
  assign addr_010_o = addr[2];
  assign addr_110_o = addr[3];
  assign addr_001_o = addr[4];
  assign addr_101_o = addr[5];
  assign addr_011_o = addr[6];
  assign addr_111_o = addr[7];

`ifndef SYNTHESIS
  // every accepted request gives a result
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("request without result");

  // a result only for an accepted request
  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_q, 2))
    else $error("result without request");

  // the volume origin always sits at address zero
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cell_x_i == '0 && cell_y_i == '0 && cell_z_i == '0)
      |-> ##3 (addr_000_o == '0))
    else $error("origin corner not at address zero");

  // the last x coordinate always leaves the largest volume
  a_edge_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cell_x_i == '1) |-> ##3 out_of_range_o)
    else $error("edge cell not flagged");
`endif

endmodule
